>>> design/b2da_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int unsigned PLACES     = 10;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned MULT_W     = 34;   // 9 * 1e9 needs 34 bits
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned CHAR_W     = 6;
    localparam int unsigned MULTS      = 9;    // multiples 1..9 of a weight
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    localparam logic [VALUE_W-1:0] PLACE_WEIGHT [PLACES] = '{
        32'd1000000000, 32'd100000000, 32'd10000000, 32'd1000000,
        32'd100000,     32'd10000,     32'd1000,     32'd100,
        32'd10,         32'd1
    };

    typedef logic [MULT_W-1:0] t_mult_row [MULTS];

    // Data handed from one cell to the next.
    typedef struct packed {
        logic               valid;
        logic               emitting;
        logic [VALUE_W-1:0] rest;
    } t_cell_bus;

    // Character a cell offers to the output.
    typedef struct packed {
        logic               strobe;
        logic [DIGIT_W-1:0] digit;
    } t_char_out;

    // j-th multiple (j = 1..9) of a place weight; elaboration only.
    function automatic logic [MULT_W-1:0] place_mult(input int unsigned place,
                                                     input int unsigned j);
        logic [63:0] prod;
        prod = 64'(PLACE_WEIGHT[place]) * 64'(j);
        return prod[MULT_W-1:0];
    endfunction

endpackage

>>> design/binary_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// 32-bit unsigned value to decimal ASCII digits, most significant first.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------
//  command  | in        | start & !busy            | i_value
//  result   | out       | o_valid, one cycle each  | o_digit_char, o_last
//
// Flow: a value runs down a row of ten place cells, billions to units,
// one cell per cycle. Each cell registers its character (cell 0 holds the
// billions); leading zeros show no strobe. busy stays high while any cell
// holds the item, so a new item is taken only once the units cell is done.
// Reset: synchronous, active low; clears the cell valid bits only.
// Stalls: the receiver cannot stall; each character is strobed once.
//
module binary_to_decimal_ascii_top
    import b2da_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] i_value,
    output logic               o_valid,
    output logic [CHAR_W-1:0]  o_digit_char,
    output logic               o_last
);

    t_cell_bus bus  [PLACES+1];
    t_char_out chars[PLACES];
    logic [PLACES-1:0] cell_valid;

    // Cell 0 is fed by the command port; a fresh item starts with no
    // leading digit seen.
    assign bus[0].valid    = start & ~busy;
    assign bus[0].emitting = 1'b0;
    assign bus[0].rest     = i_value;

    for (genvar p = 0; p < PLACES; p++) begin : g_cell
        t_mult_row mult;
        for (genvar j = 0; j < MULTS; j++) begin : g_mult
            assign mult[j] = place_mult(p, j + 1);
        end

        b2da_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_units (p == PLACES - 1),
            .i_mult  (mult),
            .i_bus   (bus[p]),
            .o_bus   (bus[p+1]),
            .o_char  (chars[p])
        );

        assign cell_valid[p] = bus[p+1].valid;
    end

    // Only one cell holds the item at a time, so the strobes are one-hot
    // and an AND-OR picks the digit.
    logic [DIGIT_W-1:0] digit;
    logic               any_strobe;

    always_comb begin
        digit      = '0;
        any_strobe = 1'b0;
        for (int p = 0; p < PLACES; p++) begin
            if (chars[p].strobe) begin
                digit = digit | chars[p].digit;
            end
            any_strobe = any_strobe | chars[p].strobe;
        end
    end

    assign busy         = |cell_valid;
    assign o_valid      = any_strobe;
    assign o_digit_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
    assign o_last       = chars[PLACES-1].strobe;

endmodule

>>> design/b2da_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_cell
// One decimal place: finds how many times its weight fits, passes the rest on.
// ----------------------------------------------------------------------------
module b2da_cell
    import b2da_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_units,
    input  t_mult_row i_mult,
    input  t_cell_bus i_bus,
    output t_cell_bus o_bus,
    output t_char_out o_char
);

    logic               r_valid;
    logic               r_emitting;
    logic [VALUE_W-1:0] r_rest;
    logic [DIGIT_W-1:0] r_digit;

    logic [DIGIT_W-1:0] n_digit;
    logic [VALUE_W-1:0] n_rest;
    logic               n_emitting;
    logic [MULT_W-1:0]  sub;

    // Parallel compares against the constant multiples; the largest that
    // fits gives the digit. Digits never exceed nine.
    always_comb begin
        n_digit = '0;
        sub     = '0;
        for (int j = 0; j < MULTS; j++) begin
            if ({{(MULT_W-VALUE_W){1'b0}}, i_bus.rest} >= i_mult[j]) begin
                n_digit = DIGIT_W'(j + 1);
                sub     = i_mult[j];
            end
        end
        n_rest     = i_bus.rest - sub[VALUE_W-1:0];
        n_emitting = i_bus.emitting | (n_digit != '0) | i_units;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_bus.valid;
        end
        r_emitting <= n_emitting;
        r_rest     <= n_rest;
        r_digit    <= n_digit;
    end

    assign o_bus.valid    = r_valid;
    assign o_bus.emitting = r_emitting;
    assign o_bus.rest     = r_rest;
    assign o_char.strobe  = r_valid & r_emitting;
    assign o_char.digit   = r_digit;

endmodule

>>> design/b2da_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_checker
// Port-level checks on the converter's command and result timing.
// ----------------------------------------------------------------------------
module b2da_checker
    import b2da_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [CHAR_W-1:0] o_digit_char,
    input logic              o_last
);

    // Taken item keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an accepted item");

    // Units digit, with last set, arrives once the item has passed all ten cells.
    a_last_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##10 (o_valid && o_last))
        else $error("last character not on time");

    // The last character is not directly followed by another.
    a_quiet_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !o_valid)
        else $error("character after last");

    // Characters only come while an item is in flight, and they are digits.
    a_valid_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (busy && o_digit_char >= ASCII_ZERO && o_digit_char <= 6'd57))
        else $error("bad character strobe");

endmodule

bind binary_to_decimal_ascii_top b2da_checker u_b2da_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_digit_char (o_digit_char),
    .o_last       (o_last)
);

>>> sim/decimal_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_checker
// Predicts the decimal ASCII text of each accepted value and checks every
// strobed character against it, in order, field by field.
// ----------------------------------------------------------------------------
module decimal_text_checker
    import b2da_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_valid,
    input  logic [CHAR_W-1:0]  i_digit_char,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
    } t_text_char;

    t_text_char expected_chars[$];
    int         fail_count = 0;

    // Repeated subtraction per decimal place, leading zeros dropped,
    // units place always kept.
    task automatic push_decimal_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        int                 digit;
        logic               emitting;
        t_text_char         ch;
        rest     = value;
        emitting = 1'b0;
        for (int p = 0; p < PLACES; p++) begin
            digit = 0;
            while (rest >= PLACE_WEIGHT[p] && digit < 9) begin
                rest  = rest - PLACE_WEIGHT[p];
                digit = digit + 1;
            end
            if (digit != 0 || emitting || p == PLACES - 1) begin
                ch.digit_char = CHAR_W'(ASCII_ZERO + digit);
                ch.last       = (p == PLACES - 1);
                expected_chars.push_back(ch);
                emitting = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n) begin
            if (i_valid) begin
                if (expected_chars.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected char 0x%0h last=%0b",
                                 $realtime, i_digit_char, i_last);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (want.digit_char !== i_digit_char || want.last !== i_last) begin
                        if (fail_count < 10)
                            $display("%0t: char mismatch exp 0x%0h/%0b got 0x%0h/%0b",
                                     $realtime, want.digit_char, want.last,
                                     i_digit_char, i_last);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                push_decimal_text(i_value);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_chars.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives values into the binary to decimal ASCII converter: a directed set
// of edge values, then random values shaped by digit count and zero runs,
// with random gaps. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import b2da_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [VALUE_W-1:0] value;
    logic               valid;
    logic [CHAR_W-1:0]  digit_char;
    logic               last;
    int                 fail_count;
    int                 pending;

    binary_to_decimal_ascii_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (value),
        .o_valid      (valid),
        .o_digit_char (digit_char),
        .o_last       (last)
    );

    decimal_text_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (value),
        .i_valid      (valid),
        .i_digit_char (digit_char),
        .i_last       (last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop; a correct run needs well under a tenth of this.
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    // Present one value and hold start until the edge that takes it
    // (start high, busy low). start stays high on return so a back-to-back
    // item needs no drop.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        start <= 1'b1;
        value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Random idle after an item; gap length is spread so the next start
    // lands on every phase of the cell row.
    task automatic maybe_idle(input bit allow);
        if (allow && $urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            value <= $urandom;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    // Value with a chosen number of decimal digits, full 32-bit range
    // for ten digits.
    function automatic logic [VALUE_W-1:0] value_of_digits(input int n);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = (n == 1) ? 64'd0 : 64'(PLACE_WEIGHT[PLACES - n]);
        hi = (n == 10) ? 64'hFFFF_FFFF : 64'(PLACE_WEIGHT[PLACES - n]) * 10 - 1;
        return VALUE_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
    endfunction

    // Few nonzero digits scattered among zeros; stresses zero places
    // after the first emitted digit.
    function automatic logic [VALUE_W-1:0] sparse_value();
        logic [63:0] acc;
        int          p;
        acc = 0;
        repeat ($urandom_range(1, 3)) begin
            p   = $urandom_range(0, PLACES - 1);
            acc = acc + 64'(PLACE_WEIGHT[p]) * $urandom_range(1, 9);
        end
        return (acc > 64'hFFFF_FFFF) ? VALUE_W'(acc % 64'd4294967296) : VALUE_W'(acc);
    endfunction

    localparam logic [VALUE_W-1:0] DIRECTED [20] = '{
        32'd0,          32'd1,          32'd9,          32'd10,
        32'd99,         32'd100,        32'hFFFF_FFFF,  32'hFFFF_FFFE,
        32'd4000000000, 32'd999999999,  32'd1000000000, 32'd1000000009,
        32'h8000_0000,  32'h7FFF_FFFF,  32'h5555_5555,  32'hAAAA_AAAA,
        32'd1234567890, 32'd9999,       32'd10000,      32'd5
    };

    initial begin
        logic [VALUE_W-1:0] v;
        int                 k;
        start <= 1'b0;
        value <= '0;
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero, field maximum, digit count boundaries at 10, 100, 10000 and 1e9,
        // alternating bit patterns (each value bit seen at 0 and 1).
        foreach (DIRECTED[i]) begin
            send_value(DIRECTED[i]);
            maybe_idle(1'b1);
        end

        // Hold off until the directed text has fully drained.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        // Random part; items 150..249 run with no idling at all.
        for (int n = 0; n < 390; n++) begin
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = value_of_digits($urandom_range(1, 10));
                2: v = sparse_value();
                default: begin
                    // a power of ten or one off it, either side
                    k = $urandom_range(0, PLACES - 1);
                    v = PLACE_WEIGHT[k] + ($urandom_range(0, 1) ? 32'd0 : -32'd1);
                    if ($urandom_range(0, 1))
                        v = v + 32'd1;
                end
            endcase
            send_value(v);
            maybe_idle(n < 150 || n >= 250);
        end

        // Drain, then let the cell row settle.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (15) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
